/* rtl/cal_pkg.sv */
package cal_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int END_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (LEN_W > END_W) ? LEN_W : END_W;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 3'd0,
        K_REMOVE = 3'd1,
        K_READ   = 3'd2,
        K_ERASE  = 3'd3,
        K_RANGE  = 3'd4,
        K_CLEAR  = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_pos;
        logic [WORD_WIDTH-1:0] wr_data;
        logic                  shift_en;
        logic [ADDR_W-1:0]     shift_from;
        logic                  pass_en;
        logic [ADDR_W-1:0]     rd_pos;
    } t_cell_ctl;

endpackage

/* rtl/cal_if.sv */
interface cal_in_if;
    import cal_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [END_W-1:0]   end_index;

    modport source (output valid, kind, value, index, end_index, input ready);
    modport sink (input valid, kind, value, index, end_index, output ready);
endinterface

interface cal_out_if;
    import cal_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  item_count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;

    modport source (output valid, read_value, item_count, is_empty, status, input ready);
    modport sink (input valid, read_value, item_count, is_empty, status, output ready);
endinterface

/* rtl/cal_cell.sv */
module cal_cell (
    input  logic                           i_clk,
    input  logic [cal_pkg::ADDR_W-1:0]     i_pos,
    input  cal_pkg::t_cell_ctl             i_ctl,
    input  logic [cal_pkg::WORD_WIDTH-1:0] i_next_word,
    input  logic [cal_pkg::WORD_WIDTH-1:0] i_next_pass,
    output logic [cal_pkg::WORD_WIDTH-1:0] o_word,
    output logic [cal_pkg::WORD_WIDTH-1:0] o_pass
);
    import cal_pkg::*;

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] r_pass;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_ctl.wr_pos == i_pos)) begin
            r_word <= i_ctl.wr_data;
        end else if (i_ctl.shift_en && (i_pos >= i_ctl.shift_from)) begin
            r_word <= i_next_word;
        end
        if (i_ctl.pass_en) begin
            r_pass <= (i_pos == i_ctl.rd_pos) ? r_word : i_next_pass;
        end
    end

    assign o_word = r_word;
    assign o_pass = r_pass;

endmodule

/* rtl/cal_ctrl.sv */
module cal_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cal_in_if.sink                         i_in,
    cal_out_if.source                      o_out,
    input  logic [cal_pkg::WORD_WIDTH-1:0] i_pass0,
    output cal_pkg::t_cell_ctl             o_ctl
);
    import cal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_READ  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [LEN_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    t_status             r_status, n_status;
    logic                r_rd_ok, n_rd_ok;
    logic                r_ovalid, n_ovalid;
    logic [VALUE_W-1:0]  r_read_value, n_read_value;
    logic [COUNT_W-1:0]  r_item_count, n_item_count;
    logic                r_is_empty, n_is_empty;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;

    logic [CMP_W-1:0] w_len;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_end;

    assign w_len = CMP_W'(r_len);
    assign w_idx = CMP_W'(i_in.index);
    assign w_end = CMP_W'(i_in.end_index);

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_status     = r_status;
        n_rd_ok      = r_rd_ok;
        n_ovalid     = r_ovalid && !o_out.ready;
        n_read_value = r_read_value;
        n_item_count = r_item_count;
        n_is_empty   = r_is_empty;
        n_ostatus    = r_ostatus;

        o_ctl            = '0;
        o_ctl.wr_pos     = ADDR_W'(r_len);
        o_ctl.wr_data    = WORD_WIDTH'(i_in.value);
        o_ctl.shift_from = r_idx;
        o_ctl.rd_pos     = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state  = S_DONE;
                    n_status = ST_OK;
                    n_rd_ok  = 1'b0;
                    n_idx    = ADDR_W'(i_in.index);
                    case (i_in.kind)
                        K_APPEND: begin
                            if (w_len >= CMP_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ctl.wr_en = 1'b1;
                                n_len       = r_len + LEN_W'(1);
                            end
                        end
                        K_REMOVE: begin
                            if (r_len != '0) begin
                                n_len = r_len - LEN_W'(1);
                            end
                        end
                        K_READ: begin
                            if (w_idx >= w_len) begin
                                n_status = ST_INDEX;
                            end else begin
                                n_rd_ok = 1'b1;
                                n_cnt   = LEN_W'(i_in.index);
                                n_state = S_READ;
                            end
                        end
                        K_ERASE: begin
                            if (w_idx >= w_len) begin
                                n_status = ST_INDEX;
                            end else begin
                                n_cnt   = LEN_W'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        K_RANGE: begin
                            if ((w_idx >= w_end) || (w_end > w_len)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_cnt   = LEN_W'(w_end - w_idx);
                                n_state = S_SHIFT;
                            end
                        end
                        K_CLEAR: begin
                            n_len = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                o_ctl.shift_en = 1'b1;
                n_len          = r_len - LEN_W'(1);
                n_cnt          = r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_ctl.pass_en = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - LEN_W'(1);
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid     = 1'b1;
                    n_read_value = r_rd_ok ? VALUE_W'(i_pass0) : '0;
                    n_item_count = COUNT_W'(r_len);
                    n_is_empty   = (r_len == '0);
                    n_ostatus    = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
        r_cnt        <= n_cnt;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_rd_ok      <= n_rd_ok;
        r_read_value <= n_read_value;
        r_item_count <= n_item_count;
        r_is_empty   <= n_is_empty;
        r_ostatus    <= n_ostatus;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.read_value = r_read_value;
    assign o_out.item_count = r_item_count;
    assign o_out.is_empty   = r_is_empty;
    assign o_out.status     = r_ostatus;

endmodule

/* rtl/compacting_array_list.sv */
// A packed list of up to CAPACITY words held in a row of cells, one word per cell. Each
// input transaction is one operation and yields exactly one output transaction with the
// word read, the length, an empty flag and a status. Append, remove last, clear and any
// rejected operation go straight to the done state, where the result is loaded into the
// output register once any earlier result has been taken; the next input transaction can
// be accepted after that. A read first walks the word one cell per cycle toward the head
// of the row. An erase of n entries first moves every later word down by n cells, one
// cell per cycle. One operation is in work at a time; the next is accepted as soon as the
// previous result is loaded into the output register, even if that result has not yet
// been taken.
module compacting_array_list (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cal_in_if.sink    i_in,
    cal_out_if.source o_out
);
    import cal_pkg::*;

    t_cell_ctl             w_ctl;
    logic [WORD_WIDTH-1:0] w_word [CAPACITY];
    logic [WORD_WIDTH-1:0] w_pass [CAPACITY];

    cal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_pass0 (w_pass[0]),
        .o_ctl   (w_ctl)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_next_word;
        logic [WORD_WIDTH-1:0] w_next_pass;

        if (g < CAPACITY - 1) begin : g_mid
            assign w_next_word = w_word[g+1];
            assign w_next_pass = w_pass[g+1];
        end else begin : g_last
            assign w_next_word = '0;
            assign w_next_pass = '0;
        end

        cal_cell u_cell (
            .i_clk       (i_clk),
            .i_pos       (ADDR_W'(g)),
            .i_ctl       (w_ctl),
            .i_next_word (w_next_word),
            .i_next_pass (w_next_pass),
            .o_word      (w_word[g]),
            .o_pass      (w_pass[g])
        );
    end

endmodule
